FILE: rtl/core/s2x_pkg.sv
// ----------------------------------------------------------------------------
// s2x_pkg
// Shared types and constants for the Scale2x 8-bit pixel upscaler.
// ----------------------------------------------------------------------------
package s2x_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int PIX_W       = 8;
	localparam int DIM_W       = 11;
	localparam int COL_W       = 10;
	localparam int ROW_W       = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(320);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(240);

	// configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// request kinds on the input stream
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	// one block to build, as classified by the front
	typedef struct packed {
		logic [PIX_W-1:0] pix;       // pixel below the center (H)
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             first_col; // D comes from E
		logic             last_col;  // F comes from E
		logic             top_row;   // B comes from E
		logic             drain;     // H comes from E
		logic             done;      // final block of the frame
	} op_t;

	// queue entry: op plus the row store reads
	typedef struct packed {
		op_t              op;
		logic [PIX_W-1:0] e;
		logic [PIX_W-1:0] b;
		logic [PIX_W-1:0] f;
	} qent_t;

endpackage

FILE: rtl/core/scale2x_pixel_upscaler_unit.sv
// ----------------------------------------------------------------------------
// scale2x_pixel_upscaler_unit
// Streaming Scale2x 2x upscaler for 8-bit indexed pixels.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order on the slave stream (tuser = 0) and
// each one becomes a 2x2 block on the master stream using the Scale2x rule
// on its four neighbors, with the frame edge repeated. The block of a pixel
// leaves once the pixel below it has arrived, so the first source row gives
// no output and the last row is released by drain requests (tuser = 1), one
// block per request; tlast marks the final block of the frame. Pixels sent
// while a drain is pending and drains with nothing pending are dropped.
// One request is taken per cycle, sustained, including across row ends; a
// block passes the row store read, the queue and the output register. Ready
// falls only when the four-entry queue between the request front end and
// the block builder, together with the block in flight through the row
// store read, would overfill, i.e. when the output side has stalled. Two
// 1024 x 8 row stores (one write, two read ports each) swap roles at every
// row end; they start undefined and need no clearing pass. Width and height
// are to be written through the config channel while the stream is idle (the
// block does not enforce it); zero is taken as one, values above 1024 as 1024.
// ----------------------------------------------------------------------------
module scale2x_pixel_upscaler_unit (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,    // 0: frame_width, 1: frame_height
	input  logic [10:0] cfg_data,
	// source stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // [7:0] pixel
	input  logic        s_tuser,      // [0] req_type
	// block stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,      // [7:0] top_left, [15:8] top_right,
	                                  // [23:16] bottom_left, [31:24] bottom_right,
	                                  // [41:32] src_col, [51:42] src_row, rest 0
	output logic        m_tlast       // frame_done
);
	import s2x_pkg::*;

	logic              push, pop, head_valid;
	qent_t             push_ent, head_ent;
	logic [QCNT_W-1:0] q_count;

	// config registers are always writable
	assign cfg_ready = 1'b1;

	// front: position tracking, row stores, classification
	s2x_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_count   (q_count),
		.push      (push),
		.push_ent  (push_ent)
	);

	// decoupling queue
	s2x_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ent   (push_ent),
		.pop        (pop),
		.head_ent   (head_ent),
		.head_valid (head_valid),
		.count      (q_count)
	);

	// back: Scale2x rule and output register
	s2x_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_ent   (head_ent),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

FILE: rtl/core/s2x_ram.sv
// ----------------------------------------------------------------------------
// s2x_ram
// Generic RAM, one write port, two read ports, registered read (old data on
// a read of the address being written).
// ----------------------------------------------------------------------------
module s2x_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

FILE: rtl/core/s2x_front.sv
// ----------------------------------------------------------------------------
// s2x_front
// Accepts requests, tracks frame position, writes and reads the two row
// stores and hands classified blocks to the queue.
// ----------------------------------------------------------------------------
module s2x_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_index,
	input  logic [s2x_pkg::DIM_W-1:0] cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [s2x_pkg::PIX_W-1:0] s_tdata,
	input  logic                      s_tuser,
	input  logic [s2x_pkg::QCNT_W-1:0] q_count,
	output logic                      push,
	output s2x_pkg::qent_t            push_ent
);
	import s2x_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [DIM_W-1:0] drain_q;
	logic             bank_q;

	logic             accept, pix_take, drn_take, emit;
	logic [DIM_W-1:0] col_plus1, row_plus1;
	logic             last_col, last_row, done;

	logic             valid_s1, bank_s1;
	op_t              op_s1;

	logic [PIX_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

	// clamp a dimension write to 1..MAX
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

	assign s_tready = (q_count + QCNT_W'(valid_s1)) < QCNT_W'(QUEUE_DEPTH);
	assign accept   = s_tvalid && s_tready;

	assign col_plus1 = {1'b0, col_q} + DIM_W'(1);
	assign row_plus1 = {1'b0, row_q} + DIM_W'(1);
	assign last_col  = col_plus1 >= width_q;
	assign last_row  = row_plus1 >= height_q;

	assign pix_take = accept && (s_tuser == REQ_PIXEL) && (drain_q == '0);
	assign drn_take = accept && (s_tuser == REQ_DRAIN) && (drain_q != '0);
	assign emit     = (pix_take && (row_q != '0)) || drn_take;
	assign done     = drn_take && (drain_q == DIM_W'(1));

	// row stores: physical store bank_q plays the older role and takes the
	// incoming row, the other one holds the last complete row
	s2x_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram0 (
		.clk     (clk),
		.we      (pix_take && !bank_q),
		.waddr   (col_q),
		.wdata   (s_tdata),
		.raddr_a (col_q),
		.rdata_a (rd0_a),
		.raddr_b (col_plus1[COL_W-1:0]),
		.rdata_b (rd0_b)
	);

	s2x_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram1 (
		.clk     (clk),
		.we      (pix_take && bank_q),
		.waddr   (col_q),
		.wdata   (s_tdata),
		.raddr_a (col_q),
		.rdata_a (rd1_a),
		.raddr_b (col_plus1[COL_W-1:0]),
		.rdata_b (rd1_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			drain_q  <= '0;
			bank_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  width_q  <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
					REG_FRAME_HEIGHT: height_q <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
					default: ;
				endcase
			end
			valid_s1 <= emit;
			if (pix_take) begin
				if (last_col) begin
					col_q  <= '0;
					bank_q <= !bank_q;
					if (last_row) begin
						drain_q <= width_q;
					end else begin
						row_q <= row_plus1[ROW_W-1:0];
					end
				end else begin
					col_q <= col_plus1[COL_W-1:0];
				end
			end else if (drn_take) begin
				drain_q <= drain_q - DIM_W'(1);
				if (done) begin
					col_q <= '0;
					row_q <= '0;
				end else begin
					col_q <= col_plus1[COL_W-1:0];
				end
			end
		end
	end

	// op metadata rides alongside the registered store read
	always_ff @(posedge clk) begin
		if (emit) begin
			bank_s1            <= bank_q;
			op_s1.pix          <= s_tdata;
			op_s1.col          <= col_q;
			op_s1.row          <= drn_take ? row_q : row_q - ROW_W'(1);
			op_s1.first_col    <= col_q == '0;
			op_s1.last_col     <= last_col;
			op_s1.top_row      <= drn_take ? (row_q == '0) : (row_q == ROW_W'(1));
			op_s1.drain        <= drn_take;
			op_s1.done         <= done;
		end
	end

	assign push        = valid_s1;
	assign push_ent.op = op_s1;
	assign push_ent.e  = bank_s1 ? rd0_a : rd1_a;
	assign push_ent.b  = bank_s1 ? rd1_a : rd0_a;
	assign push_ent.f  = bank_s1 ? rd0_b : rd1_b;

	ap_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (col_q == '0 && row_q == '0 && drain_q == '0))
		else $error("frame end did not rewind position");

	ap_no_write_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_q != '0) |-> !pix_take)
		else $error("row store written while draining");

endmodule

FILE: rtl/core/s2x_queue.sv
// ----------------------------------------------------------------------------
// s2x_queue
// Short FIFO between the front and the block builder.
// ----------------------------------------------------------------------------
module s2x_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  s2x_pkg::qent_t             push_ent,
	input  logic                       pop,
	output s2x_pkg::qent_t             head_ent,
	output logic                       head_valid,
	output logic [s2x_pkg::QCNT_W-1:0] count
);
	import s2x_pkg::*;

	qent_t             ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head_ent   = ent_q[rd_ptr_q];
	assign head_valid = count_q != '0;
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	ap_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QCNT_W'(QUEUE_DEPTH) || pop))
		else $error("queue overflow");

	ap_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue underflow");

endmodule

FILE: rtl/core/s2x_back.sv
// ----------------------------------------------------------------------------
// s2x_back
// Builds the 2x2 block from the queued neighbors and holds it in the
// output register.
// ----------------------------------------------------------------------------
module s2x_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  s2x_pkg::qent_t head_ent,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [55:0]    m_tdata,
	output logic           m_tlast
);
	import s2x_pkg::*;

	logic [PIX_W-1:0] last_e_q;
	logic             out_valid_q;
	logic             out_last_q;
	logic [55:0]      out_data_q;

	logic [PIX_W-1:0] e, b, d, f, h;
	logic [PIX_W-1:0] tl, tr, bl, br;

	assign pop = head_valid && (!out_valid_q || m_tready);

	// left neighbor is the center of the previous block in the same row
	always_comb begin
		e = head_ent.e;
		b = head_ent.op.top_row   ? e : head_ent.b;
		d = head_ent.op.first_col ? e : last_e_q;
		f = head_ent.op.last_col  ? e : head_ent.f;
		h = head_ent.op.drain     ? e : head_ent.op.pix;
		if (b != h && d != f) begin
			tl = (d == b) ? d : e;
			tr = (b == f) ? f : e;
			bl = (d == h) ? d : e;
			br = (h == f) ? f : e;
		end else begin
			tl = e;
			tr = e;
			bl = e;
			br = e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			last_e_q   <= e;
			out_last_q <= head_ent.op.done;
			out_data_q <= {4'b0, head_ent.op.row, head_ent.op.col, br, bl, tr, tl};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	ap_done_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_ent.op.done) |-> head_ent.op.drain)
		else $error("frame end flagged on a pixel block");

	ap_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !pop)
		else $error("output register overwritten while stalled");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Scale2x pixel upscaler. Frames of source pixels
// and drain requests go in through a bursty stream driver; a monitor predicts
// each 2x2 block from its own row stores and compares every block it sees
// on the output stream, while the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb;
	import s2x_pkg::*;

	localparam int CYCLE_LIMIT  = 500_000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int SETTLE       = 12;    // cycles to let a request with no block retire
	localparam int SQUEEZE_LEN  = 400;   // one long output hold-off

	typedef struct packed {
		logic       kind;
		logic [7:0] pix;
	} src_item_t;

	typedef struct packed {
		logic [7:0] tl;
		logic [7:0] tr;
		logic [7:0] bl;
		logic [7:0] br;
		logic [9:0] col;
		logic [9:0] row;
		logic       done;
	} block_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_FRAME_WIDTH;
	logic [10:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tuser   = REQ_PIXEL;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tlast;

	scale2x_pixel_upscaler_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor state: two row stores that swap roles at each row end
	// ------------------------------------------------------------------------
	logic [7:0]  row_a [MAX_WIDTH];
	logic [7:0]  row_b [MAX_WIDTH];
	bit          bank       = 1'b0;
	int unsigned col_cnt    = 0;
	int unsigned row_cnt    = 0;
	int unsigned drain_left = 0;
	logic [10:0] width_reg  = WIDTH_RESET;
	logic [10:0] height_reg = HEIGHT_RESET;

	block_t    pending_blocks[$];
	src_item_t src_items[$];

	int errors       = 0;
	int blocks_seen  = 0;
	int frames_done  = 0;
	int items_in     = 0;
	int cfg_writes   = 0;
	int frame_items  = 0;
	int cycles       = 0;

	function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// newer = 1 picks the store with the last complete row
	function automatic logic [7:0] row_rd(bit newer, int unsigned idx);
		int unsigned i;
		i = (idx >= MAX_WIDTH) ? MAX_WIDTH - 1 : idx;
		return (bank ^ newer) ? row_b[i] : row_a[i];
	endfunction

	function automatic void gather_window(input int unsigned r, c, w,
		output logic [7:0] e, b, d, f);
		e = row_rd(1'b1, c);
		b = (r > 0) ? row_rd(1'b0, c) : e;
		d = (c > 0) ? row_rd(1'b1, c - 1) : e;
		f = (c + 1 < w) ? row_rd(1'b1, c + 1) : e;
	endfunction

	function automatic block_t make_block(logic [7:0] e, b, d, f, h,
		int unsigned c, int unsigned r, logic done);
		block_t blk;
		if (b != h && d != f) begin
			blk.tl = (d == b) ? d : e;
			blk.tr = (b == f) ? f : e;
			blk.bl = (d == h) ? d : e;
			blk.br = (h == f) ? f : e;
		end else begin
			blk.tl = e;
			blk.tr = e;
			blk.bl = e;
			blk.br = e;
		end
		blk.col  = c[9:0];
		blk.row  = r[9:0];
		blk.done = done;
		return blk;
	endfunction

	// one accepted request -> zero or one expected block
	function automatic void upscale_step(logic kind, logic [7:0] px);
		int unsigned w, hgt, c;
		logic [7:0]  e, b, d, f;
		w   = clamp_dim(width_reg, MAX_WIDTH);
		hgt = clamp_dim(height_reg, MAX_HEIGHT);
		c   = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
		if (kind == REQ_PIXEL) begin
			if (drain_left != 0)
				return;     // pixel during drain is dropped
			if (row_cnt > 0) begin
				gather_window(row_cnt - 1, c, w, e, b, d, f);
				pending_blocks.push_back(make_block(e, b, d, f, px, c, row_cnt - 1, 1'b0));
			end
			if (bank)
				row_b[c] = px;
			else
				row_a[c] = px;
			if (c + 1 >= w) begin
				col_cnt = 0;
				bank    = ~bank;
				if (row_cnt + 1 >= hgt)
					drain_left = w;
				else
					row_cnt++;
			end else begin
				col_cnt = c + 1;
			end
		end else begin
			if (drain_left == 0)
				return;     // nothing to drain
			gather_window(row_cnt, c, w, e, b, d, f);
			drain_left--;
			pending_blocks.push_back(make_block(e, b, d, f, e, c, row_cnt,
				drain_left == 0));
			if (drain_left == 0) begin
				col_cnt = 0;
				row_cnt = 0;
			end else begin
				col_cnt = c + 1;
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Receiver: pattern-driven ready, plus one long hold-off
	// ------------------------------------------------------------------------
	logic       squeeze_arm  = 1'b0;
	bit         squeeze_used = 1'b0;
	int         rx_hold      = 0;
	int         rx_mode      = 0;
	int         rx_left      = 0;
	logic [7:0] rx_pat       = 8'hff;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready     <= 1'b0;
			rx_hold      <= 0;
			rx_mode      <= 0;
			rx_left      <= 0;
			rx_pat       <= 8'hff;
			squeeze_used <= 1'b0;
		end else if (rx_hold != 0) begin
			m_tready <= 1'b0;
			rx_hold  <= rx_hold - 1;
		end else if (squeeze_arm && !squeeze_used) begin
			// output side goes quiet so the block backs up into its input
			m_tready     <= 1'b0;
			rx_hold      <= SQUEEZE_LEN;
			squeeze_used <= 1'b1;
		end else if (rx_left == 0) begin
			rx_mode  <= $urandom_range(0, 3);
			rx_left  <= $urandom_range(16, 96);
			rx_pat   <= 8'($urandom_range(0, 255)) | 8'h01;
			m_tready <= 1'b1;
		end else begin
			rx_left <= rx_left - 1;
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: begin
					m_tready <= rx_pat[0];
					rx_pat   <= {rx_pat[0], rx_pat[7:1]};
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Driver: bursts from the request queue with random gaps
	// ------------------------------------------------------------------------
	int        burst_left = 0;
	int        gap_left   = 0;
	src_item_t drv_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= REQ_PIXEL;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!s_tvalid || s_tready) begin
			// keep offering through the hold-off so the input stalls
			if (gap_left != 0 && rx_hold == 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (src_items.size() != 0) begin
				drv_item = src_items.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= drv_item.pix;
				s_tuser  <= drv_item.kind;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: predict on every input transfer, check every output transfer
	// ------------------------------------------------------------------------
	block_t exp_blk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				cfg_writes++;
				if (cfg_index == REG_FRAME_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				items_in++;
				upscale_step(s_tuser, s_tdata);
			end
			if (m_tvalid && m_tready) begin
				blocks_seen++;
				if (m_tlast)
					frames_done++;
				if (pending_blocks.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected block: data %014h last %0b", m_tdata, m_tlast);
				end else begin
					exp_blk = pending_blocks.pop_front();
					if (m_tdata[7:0] !== exp_blk.tl || m_tdata[15:8] !== exp_blk.tr ||
					    m_tdata[23:16] !== exp_blk.bl || m_tdata[31:24] !== exp_blk.br ||
					    m_tdata[41:32] !== exp_blk.col || m_tdata[51:42] !== exp_blk.row ||
					    m_tlast !== exp_blk.done) begin
						errors++;
						if (errors <= 10)
							$display({"block %0d mismatch: exp tl %02h tr %02h bl %02h br %02h",
								" col %0d row %0d last %0b / got tl %02h tr %02h bl %02h",
								" br %02h col %0d row %0d last %0b"},
								blocks_seen, exp_blk.tl, exp_blk.tr, exp_blk.bl,
								exp_blk.br, exp_blk.col, exp_blk.row, exp_blk.done,
								m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
								m_tdata[31:24], m_tdata[41:32], m_tdata[51:42], m_tlast);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d blocks outstanding", cycles,
				pending_blocks.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic push_item(logic kind, logic [7:0] px);
		src_item_t it;
		it.kind = kind;
		it.pix  = px;
		src_items.push_back(it);
	endtask

	task automatic wait_idle();
		while (src_items.size() != 0 || s_tvalid)
			@(negedge clk);
		while (pending_blocks.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [10:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_frame(logic [10:0] w_raw, logic [10:0] h_raw);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, w_raw);
		write_reg(REG_FRAME_HEIGHT, h_raw);
	endtask

	// whole frame at the current size; mode picks how repetitive the pixels are
	task automatic queue_frame(int mode, bit noisy);
		int unsigned w, h;
		logic [7:0]  pal [4];
		logic [7:0]  px;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		foreach (pal[i])
			pal[i] = 8'($urandom_range(0, 255));
		if (noisy && $urandom_range(0, 1))
			push_item(REQ_DRAIN, 8'($urandom_range(0, 255)));   // nothing pending yet
		for (int unsigned n = 0; n < w * h; n++) begin
			case (mode)
				0: px = 8'($urandom_range(0, 255));
				1: px = pal[$urandom_range(0, 1)];
				default: px = pal[$urandom_range(0, 3)];
			endcase
			push_item(REQ_PIXEL, px);
		end
		if (noisy)
			push_item(REQ_PIXEL, 8'($urandom_range(0, 255)));   // dropped while draining
		for (int unsigned n = 0; n < w; n++)
			push_item(REQ_DRAIN, 8'($urandom_range(0, 255)));
		if (noisy && $urandom_range(0, 1))
			push_item(REQ_DRAIN, 8'($urandom_range(0, 255)));   // drain past frame end
		frame_items += w * h + w;
	endtask

	initial begin
		logic [10:0] w_raw, h_raw;
		int          rand_base;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(negedge clk);

		// directed: 3x3 frame with neighbor matches, 0/255 values, drain noise
		set_frame(11'd3, 11'd3);
		push_item(REQ_DRAIN, 8'h00);
		push_item(REQ_PIXEL, 8'd1);
		push_item(REQ_PIXEL, 8'd2);
		push_item(REQ_PIXEL, 8'd3);
		push_item(REQ_PIXEL, 8'd2);
		push_item(REQ_PIXEL, 8'd2);
		push_item(REQ_PIXEL, 8'd4);
		push_item(REQ_PIXEL, 8'h00);
		push_item(REQ_PIXEL, 8'hff);
		push_item(REQ_PIXEL, 8'hff);
		push_item(REQ_PIXEL, 8'h55);
		push_item(REQ_DRAIN, 8'hff);
		push_item(REQ_DRAIN, 8'h00);
		push_item(REQ_DRAIN, 8'haa);
		push_item(REQ_DRAIN, 8'h00);

		// zero size registers are taken as one: single pixel, single drain
		set_frame(11'd0, 11'd0);
		push_item(REQ_PIXEL, 8'hff);
		push_item(REQ_DRAIN, 8'h00);

		// wide single row; then a tall column, one pixel wide
		set_frame(11'd180, 11'd1);
		queue_frame(2, 1'b0);
		set_frame(11'd0, 11'd60);
		queue_frame(1, 1'b0);
		set_frame(11'd1, 11'd2);
		queue_frame(0, 1'b1);

		// long output hold-off while a full frame keeps coming in
		set_frame(11'd16, 11'd4);
		queue_frame(0, 1'b0);
		squeeze_arm <= 1'b1;

		// random frames, mostly small, some back to back at the same size
		rand_base = frame_items;
		while (frame_items - rand_base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) != 0) begin
				w_raw = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(13, 64))
					: 11'($urandom_range(0, 12));
				h_raw = 11'($urandom_range(0, 7));
				set_frame(w_raw, h_raw);
			end
			queue_frame($urandom_range(0, 2), $urandom_range(0, 4) == 0);
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (pending_blocks.size() != 0) begin
			errors++;
			$display("%0d expected blocks never arrived", pending_blocks.size());
		end
		$display("covered %0d frames, %0d request transfers, %0d blocks checked",
			frames_done, items_in, blocks_seen);
		$display("%0d register writes, one %0d-cycle output hold-off, %0d cycles",
			cfg_writes, SQUEEZE_LEN, cycles);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/s2x_pkg.sv
rtl/core/s2x_ram.sv
rtl/core/s2x_front.sv
rtl/core/s2x_queue.sv
rtl/core/s2x_back.sv
rtl/core/scale2x_pixel_upscaler_unit.sv
dv/tb.sv
